// ===== rtl/core/bsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// Request and response payloads, opcodes, status codes and the byte-level
// helper used by the next-set-bit cursor block.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Width of a byte address taken from a 10-bit bit position
  localparam int BYTE_AW = 7;

  typedef enum logic [3:0] {
    OP_SET     = 4'd0,
    OP_TOGGLE  = 4'd1,
    OP_CLR_BIT = 4'd2,
    OP_TEST    = 4'd3,
    OP_REWIND  = 4'd4,
    OP_PEEK    = 4'd5,
    OP_TAKE    = 4'd6,
    OP_CLR_ALL = 4'd7,
    OP_EMPTY   = 4'd8
  } bsc_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NONE  = 2'd2
  } bsc_status_t;

  typedef struct packed {
    logic [1:0] status;
    logic       flag;
    logic [9:0] position;
  } bsc_rsp_t;

  // Store write request
  typedef struct packed {
    logic               we;
    logic [BYTE_AW-1:0] addr;
    logic [7:0]         data;
  } bsc_wr_t;

  // Byte unit result
  typedef struct packed {
    logic       hit;
    logic [2:0] pos;
    logic [7:0] new_byte;
    logic       test;
  } bsc_unit_res_t;

  localparam logic [7:0] ODD_MASK  = 8'hAA;
  localparam logic [7:0] PAIR_MASK = 8'hCC;
  localparam logic [7:0] HIGH_MASK = 8'hF0;
  localparam logic [2:0] BIT_MASK  = 3'h7;

  // Bit number of the single set bit in a one-hot byte
  function automatic logic [2:0] onehot_to_pos(logic [7:0] v);
    logic [2:0] p;
    p[0] = |(v & ODD_MASK);
    p[1] = |(v & PAIR_MASK);
    p[2] = |(v & HIGH_MASK);
    return p;
  endfunction

endpackage

// ===== rtl/core/bsc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_req_if: request channel
// Valid/ready channel that carries an opcode and a bit position.
// ----------------------------------------------------------------------------
interface bsc_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] op;
  logic [9:0] bit_index;

  modport source (output valid, output op, output bit_index, input ready);
  modport sink   (input valid, input op, input bit_index, output ready);
endinterface

// ===== rtl/core/bsc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_rsp_if: response channel
// Valid/ready channel that carries status, flag and found position.
// ----------------------------------------------------------------------------
interface bsc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       flag;
  logic [9:0] position;

  modport source (output valid, output status, output flag, output position, input ready);
  modport sink   (input valid, input status, input flag, input position, output ready);
endinterface

// ===== rtl/core/bitset_with_next_set_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitset_with_next_set_cursor: bitmap with next-set-bit cursor
// Membership bitmap of 8*STORE_BYTES bits with single-bit ops, test, empty
// query and a walking cursor that finds the next set bit.
//
//   channel  dir  handshake          payload
//   in_if    in   valid / ready      op[3:0], bit_index[9:0]
//   out_if   out  valid / ready      status[1:0], flag, position[9:0]
//
// One request at a time. Rewind, clear all, empty query, out-of-range
// positions and unused opcodes pass straight to the finish state; bit ops
// and test do one memory read, then one read-modify-write. Peek and take
// scan one byte per cycle through the shared byte unit, at most STORE_BYTES
// bytes per request. Reset (synchronous) clears the bitmap at once through
// valid bits. A stalled response holds in the output register; the next
// request is accepted meanwhile and finishes once the register frees up.
// ----------------------------------------------------------------------------
module bitset_with_next_set_cursor #(
  parameter int STORE_BYTES = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  bsc_req_if.sink  in_if,
  bsc_rsp_if.source out_if
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int TOTAL_BITS = STORE_BYTES * 8;
  localparam logic [7:0]    NBYTES   = 8'(STORE_BYTES);
  localparam logic [10:0]   NBITS    = 11'(TOTAL_BITS);
  localparam logic [9:0]    LAST_BIT = 10'(TOTAL_BITS - 1);
  localparam logic [AW-1:0] LAST_BYTE = AW'(STORE_BYTES - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [3:0]        op_r, op_nxt;
  logic [9:0]        bidx_r, bidx_nxt;
  logic [9:0]        cursor_r, cursor_nxt;
  logic              at_end_r, at_end_nxt;
  logic [AW-1:0]     scan_r, scan_nxt;
  logic              first_r, first_nxt;
  bsc_pkg::bsc_rsp_t res_r, res_nxt;
  bsc_pkg::bsc_rsp_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  bsc_pkg::bsc_wr_t              wr;
  logic                          clr;
  logic [bsc_pkg::BYTE_AW-1:0]   rd_addr;
  logic [7:0]                    rd_data;
  logic                          empty;
  bsc_pkg::bsc_unit_res_t        unit;
  logic                          accept;
  logic                          out_free;
  logic [9:0]                    found;

  // byte store
  bsc_store #(.STORE_BYTES(STORE_BYTES)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (wr),
    .clr_i     (clr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .empty_o   (empty)
  );

  // shared byte unit
  bsc_byte_unit u_unit (
    .data_i  (rd_data),
    .first_i (first_r),
    .start_i (cursor_r[2:0]),
    .bit_i   (bidx_r[2:0]),
    .op_i    (op_r),
    .res_o   (unit)
  );

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign found       = {7'(scan_r), unit.pos};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    bidx_nxt      = bidx_r;
    cursor_nxt    = cursor_r;
    at_end_nxt    = at_end_r;
    scan_nxt      = scan_r;
    first_nxt     = first_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    wr            = '0;
    clr           = 1'b0;
    rd_addr       = in_if.bit_index[9:3];

    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.op == bsc_pkg::OP_PEEK || in_if.op == bsc_pkg::OP_TAKE)
          rd_addr = cursor_r[9:3];
        if (accept) begin
          op_nxt    = in_if.op;
          bidx_nxt  = in_if.bit_index;
          res_nxt   = '0;
          state_nxt = S_FIN;
          unique case (bsc_pkg::bsc_op_t'(in_if.op))
            bsc_pkg::OP_SET, bsc_pkg::OP_TOGGLE,
            bsc_pkg::OP_CLR_BIT, bsc_pkg::OP_TEST: begin
              if ({1'b0, in_if.bit_index[9:3]} >= NBYTES) res_nxt.status = bsc_pkg::ST_RANGE;
              else state_nxt = S_EXEC;
            end
            bsc_pkg::OP_REWIND: begin
              cursor_nxt = '0;
              at_end_nxt = 1'b0;
            end
            bsc_pkg::OP_PEEK, bsc_pkg::OP_TAKE: begin
              if (at_end_r) begin
                res_nxt.status = bsc_pkg::ST_NONE;
              end else if ({1'b0, cursor_r} >= NBITS) begin
                res_nxt.status = bsc_pkg::ST_NONE;
                if (in_if.op == bsc_pkg::OP_TAKE) at_end_nxt = 1'b1;
              end else begin
                scan_nxt  = cursor_r[3+AW-1:3];
                first_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            bsc_pkg::OP_CLR_ALL: begin
              clr        = 1'b1;
              cursor_nxt = '0;
              at_end_nxt = 1'b0;
            end
            bsc_pkg::OP_EMPTY: res_nxt.flag = empty;
            default: ;
          endcase
        end
      end

      // read-modify-write of one byte
      S_EXEC: begin
        wr.we   = (op_r == bsc_pkg::OP_SET) || (op_r == bsc_pkg::OP_TOGGLE) ||
                  (op_r == bsc_pkg::OP_CLR_BIT);
        wr.addr = bidx_r[9:3];
        wr.data = unit.new_byte;
        res_nxt.flag = (op_r == bsc_pkg::OP_TEST) ? unit.test : 1'b0;
        state_nxt = S_FIN;
      end

      // one byte per cycle; next address issued alongside
      S_SCAN: begin
        rd_addr   = 7'(AW'(scan_r + AW'(1)));
        first_nxt = 1'b0;
        if (unit.hit) begin
          res_nxt.position = found;
          if (op_r == bsc_pkg::OP_TAKE) begin
            if (found == LAST_BIT) begin
              cursor_nxt = '0;
              at_end_nxt = 1'b1;
            end else begin
              cursor_nxt = found + 10'd1;
            end
          end
          state_nxt = S_FIN;
        end else if (scan_r == LAST_BYTE) begin
          res_nxt.status = bsc_pkg::ST_NONE;
          if (op_r == bsc_pkg::OP_TAKE) at_end_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end

      // hand the result to the output register
      S_FIN: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      at_end_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      at_end_r    <= at_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    bidx_r  <= bidx_nxt;
    scan_r  <= scan_nxt;
    first_r <= first_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.status   = out_r.status;
  assign out_if.flag     = out_r.flag;
  assign out_if.position = out_r.position;

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_if.ready)
    else $error("request accepted while busy");

  // one-hot state encoding holds
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  // scan stays inside the store
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ({1'b0, 7'(scan_r)} < NBYTES))
    else $error("scan beyond last byte");

  // an error response carries no flag and no position
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != bsc_pkg::ST_OK) |->
      (!out_r.flag && out_r.position == '0))
    else $error("error response with data");

  // a pending result waits for a free output register
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_if.ready) |=> (state_r == S_FIN))
    else $error("result dropped on stalled output");

endmodule

// ===== rtl/core/bsc_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_store: bitmap byte memory
// One write and one registered read per cycle. Per-byte valid bits give the
// all-zero reset and clear-all at once; a count of nonzero bytes
// answers the empty query.
// ----------------------------------------------------------------------------
module bsc_store #(
  parameter int STORE_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bsc_pkg::bsc_wr_t              wr_i,
  input  logic                          clr_i,
  input  logic [bsc_pkg::BYTE_AW-1:0]   rd_addr_i,
  output logic [7:0]                    rd_data_o,
  output logic                          empty_o
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CW = $clog2(STORE_BYTES + 1);

  logic [7:0]             mem [STORE_BYTES];
  logic [7:0]             rd_data_r;
  logic                   rvld_r;
  logic [STORE_BYTES-1:0] vld_r;
  logic [STORE_BYTES-1:0] nz_r;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [AW-1:0]          wa, ra;
  logic                   old_nz, new_nz;

  assign wa = wr_i.addr[AW-1:0];
  assign ra = rd_addr_i[AW-1:0];

  // memory array
  always_ff @(posedge clk) begin
    if (wr_i.we) mem[wa] <= wr_i.data;
    rd_data_r <= mem[ra];
    rvld_r    <= vld_r[ra];
  end

  // never-written bytes read as zero
  assign rd_data_o = rvld_r ? rd_data_r : 8'h00;

  // nonzero byte count
  assign old_nz = vld_r[wa] & nz_r[wa];
  assign new_nz = |wr_i.data;

  always_comb begin
    cnt_nxt = cnt_r;
    if (old_nz && !new_nz) cnt_nxt = cnt_r - CW'(1);
    else if (!old_nz && new_nz) cnt_nxt = cnt_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_i) begin
      vld_r <= '0;
      nz_r  <= '0;
      cnt_r <= '0;
    end else if (wr_i.we) begin
      vld_r[wa] <= 1'b1;
      nz_r[wa]  <= new_nz;
      cnt_r     <= cnt_nxt;
    end
  end

  assign empty_o = (cnt_r == '0);

  // count tracks the nonzero flags
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_r & nz_r) == int'(cnt_r))
    else $error("nonzero byte count out of step");

  // a nonzero flag only on a written byte
  a_nz_vld: assert property (@(posedge clk) disable iff (!rst_n)
    (nz_r & ~vld_r) == '0)
    else $error("nonzero flag on unwritten byte");

  // clear-all leaves the set empty
  a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_i |=> empty_o)
    else $error("set not empty after clear");

endmodule

// ===== rtl/core/bsc_byte_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_byte_unit: shared byte unit
// Finds the lowest set bit of a byte from an optional start bit up, and
// forms the set / toggle / clear result and the test bit for one position.
// ----------------------------------------------------------------------------
module bsc_byte_unit (
  input  logic [7:0]             data_i,
  input  logic                   first_i,
  input  logic [2:0]             start_i,
  input  logic [2:0]             bit_i,
  input  logic [3:0]             op_i,
  output bsc_pkg::bsc_unit_res_t res_o
);

  logic [7:0] keep, v, low, mask;

  // search: drop bits under the start in the first byte, isolate lowest
  always_comb begin
    keep = first_i ? (8'hFF << (start_i & bsc_pkg::BIT_MASK)) : 8'hFF;
    v    = data_i & keep;
    low  = v & (~v + 8'd1);
  end

  // single-bit update
  assign mask = 8'h01 << bit_i;

  always_comb begin
    res_o.hit  = |v;
    res_o.pos  = bsc_pkg::onehot_to_pos(low);
    res_o.test = |(data_i & mask);
    unique case (bsc_pkg::bsc_op_t'(op_i))
      bsc_pkg::OP_SET:     res_o.new_byte = data_i | mask;
      bsc_pkg::OP_TOGGLE:  res_o.new_byte = data_i ^ mask;
      bsc_pkg::OP_CLR_BIT: res_o.new_byte = data_i & ~mask;
      default:             res_o.new_byte = data_i;
    endcase
  end

endmodule
